[design/rclo_pkg.sv]
// shared types, register codes and constants of the ray cast log-odds core
`timescale 1ns / 1ps
`default_nettype none
package rclo_pkg;

  localparam int COORD_BITS     = 6;
  localparam int LOG_ODDS_BITS  = 16;
  localparam int CELL_BITS      = 3 * COORD_BITS;
  localparam int CELL_COUNT     = 1 << CELL_BITS;
  localparam int CNT_BITS       = COORD_BITS + 1;
  localparam int ERR_BITS       = COORD_BITS + 3;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [COORD_BITS-1:0]           coord_t;
  typedef logic signed [LOG_ODDS_BITS-1:0] log_odds_t;
  typedef logic [CELL_BITS-1:0]            cell_addr_t;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } ray_req_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] cells_updated;
    log_odds_t           end_log_odds;
    logic                end_occupied;
  } ray_rsp_t;

  localparam logic KIND_RAY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FREE_DELTA     = 3'd0,
    REG_OCCUPIED_DELTA = 3'd1,
    REG_LOG_ODDS_MIN   = 3'd2,
    REG_LOG_ODDS_MAX   = 3'd3,
    REG_OCC_THRESHOLD  = 3'd4
  } cfg_reg_t;

  localparam log_odds_t FREE_DELTA_RST     = log_odds_t'(-1638);
  localparam log_odds_t OCCUPIED_DELTA_RST = log_odds_t'(3482);
  localparam log_odds_t LOG_ODDS_MIN_RST   = log_odds_t'(-8192);
  localparam log_odds_t LOG_ODDS_MAX_RST   = log_odds_t'(14336);
  localparam log_odds_t OCC_THRESHOLD_RST  = log_odds_t'(0);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_DIFF  = 3'd2,
    S_AXIS  = 3'd3,
    S_WALK  = 3'd4,
    S_READ  = 3'd5,
    S_DRAIN = 3'd6
  } state_t;

endpackage
`default_nettype wire

[design/rclo_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module rclo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/ray_cast_log_odds_update_core.sv]
// top level: 3d bresenham ray walk with saturating log-odds update of a voxel grid
//
// channel  ports                          direction  handshake
// request  start, busy, in_data           in         accepted when start && !busy
// result   out_valid, out_data            out        one-cycle strobe, no stall
// config   cfg_we, cfg_index, cfg_data    in         write when cfg_we, no wait
//
// a ray passes the diff, axis, walk and drain states from accept to result strobe
// a read passes the read then the drain state; one grid read-modify-write per voxel sets the walk rate
// reads and writes use separate ram ports, so one voxel retires per walk cycle
// after reset a clearing pass zeroes all 262144 grid cells with busy high
// the result strobe cannot be stalled; the next request is taken while it shows
`timescale 1ns / 1ps
`default_nettype none
module ray_cast_log_odds_update_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire rclo_pkg::ray_req_t                    in_data,
  output logic                                       out_valid,
  output rclo_pkg::ray_rsp_t                         out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [rclo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [rclo_pkg::LOG_ODDS_BITS-1:0]    cfg_data
);
  import rclo_pkg::*;

  state_t state_r, state_nxt;

  log_odds_t free_delta_r, occupied_delta_r, lo_min_r, lo_max_r, occ_thresh_r;

  ray_req_t  req_r;
  coord_t    s_coord [3];
  coord_t    e_coord [3];

  coord_t    pos_r [3];
  coord_t    d_r [3];
  logic      dir_r [3];
  logic signed [ERR_BITS-1:0] err_r [3];
  axis_t     axis_r;
  coord_t    da_r;
  coord_t    step_r;
  logic      walk_last;

  coord_t    pos_nxt [3];
  logic signed [ERR_BITS-1:0] err_nxt [3];
  logic signed [ERR_BITS-1:0] da_x2;

  axis_t     axis_sel;
  coord_t    da_sel;

  cell_addr_t clr_addr_r;

  // read-modify-write stage: data of p1_addr_r arrives from the ram this cycle
  logic       p1_valid_r, p1_write_r, p1_last_r;
  cell_addr_t p1_addr_r;
  logic [CNT_BITS-1:0] p1_cnt_r;

  logic                out_valid_r;
  logic [CNT_BITS-1:0] out_cnt_r;
  log_odds_t           out_lo_r;

  logic       mem_we;
  cell_addr_t mem_waddr, mem_raddr;
  log_odds_t  mem_wdata, mem_rdata;

  log_odds_t                   delta_sel;
  logic signed [LOG_ODDS_BITS:0] sum;
  log_odds_t                   sat_val;

  assign s_coord[0] = req_r.start_x;
  assign s_coord[1] = req_r.start_y;
  assign s_coord[2] = req_r.start_z;
  assign e_coord[0] = req_r.end_x;
  assign e_coord[1] = req_r.end_y;
  assign e_coord[2] = req_r.end_z;

  assign walk_last = (step_r == da_r);

  // driving axis, ties go to x then y
  always_comb begin
    if (d_r[0] >= d_r[1] && d_r[0] >= d_r[2]) begin
      axis_sel = AXIS_X;
      da_sel   = d_r[0];
    end else if (d_r[1] >= d_r[0] && d_r[1] >= d_r[2]) begin
      axis_sel = AXIS_Y;
      da_sel   = d_r[1];
    end else begin
      axis_sel = AXIS_Z;
      da_sel   = d_r[2];
    end
  end

  // one bresenham step; the driving axis always steps
  assign da_x2 = $signed({2'b00, da_r, 1'b0});
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic stp;
      stp = (axis_r == axis_t'(i)) || !err_r[i][ERR_BITS-1];
      if (stp) begin
        pos_nxt[i] = dir_r[i] ? pos_r[i] + 1'b1 : pos_r[i] - 1'b1;
        err_nxt[i] = err_r[i] - da_x2 + $signed({2'b00, d_r[i], 1'b0});
      end else begin
        pos_nxt[i] = pos_r[i];
        err_nxt[i] = err_r[i] + $signed({2'b00, d_r[i], 1'b0});
      end
    end
  end

  // saturating add of the cell just read
  assign delta_sel = p1_last_r ? occupied_delta_r : free_delta_r;
  assign sum = {mem_rdata[LOG_ODDS_BITS-1], mem_rdata}
             + {delta_sel[LOG_ODDS_BITS-1], delta_sel};
  always_comb begin
    priority if (sum > $signed({lo_max_r[LOG_ODDS_BITS-1], lo_max_r})) begin
      sat_val = lo_max_r;
    end else if (sum < $signed({lo_min_r[LOG_ODDS_BITS-1], lo_min_r})) begin
      sat_val = lo_min_r;
    end else begin
      sat_val = sum[LOG_ODDS_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) state_nxt = (in_data.kind == KIND_READ) ? S_READ : S_DIFF;
      end
      S_DIFF:  state_nxt = S_AXIS;
      S_AXIS:  state_nxt = S_WALK;
      S_WALK:  if (walk_last) state_nxt = S_DRAIN;
      S_READ:  state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    busy      = (state_r != S_IDLE);
    mem_raddr = {pos_r[2], pos_r[1], pos_r[0]};
    if (state_r == S_READ) begin
      mem_raddr = {req_r.end_z, req_r.end_y, req_r.end_x};
    end
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = p1_valid_r && p1_write_r;
      mem_waddr = p1_addr_r;
      mem_wdata = sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_addr_r       <= '0;
      free_delta_r     <= FREE_DELTA_RST;
      occupied_delta_r <= OCCUPIED_DELTA_RST;
      lo_min_r         <= LOG_ODDS_MIN_RST;
      lo_max_r         <= LOG_ODDS_MAX_RST;
      occ_thresh_r     <= OCC_THRESHOLD_RST;
      p1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FREE_DELTA:     free_delta_r     <= cfg_data;
          REG_OCCUPIED_DELTA: occupied_delta_r <= cfg_data;
          REG_LOG_ODDS_MIN:   lo_min_r         <= cfg_data;
          REG_LOG_ODDS_MAX:   lo_max_r         <= cfg_data;
          REG_OCC_THRESHOLD:  occ_thresh_r     <= cfg_data;
          default: ;
        endcase
      end
      p1_valid_r  <= (state_r == S_WALK) || (state_r == S_READ);
      out_valid_r <= p1_valid_r && p1_last_r;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_data;
    end
    if (state_r == S_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= (e_coord[i] > s_coord[i]) ? e_coord[i] - s_coord[i]
                                              : s_coord[i] - e_coord[i];
        dir_r[i] <= (e_coord[i] > s_coord[i]);
        pos_r[i] <= s_coord[i];
      end
    end
    if (state_r == S_AXIS) begin
      axis_r <= axis_sel;
      da_r   <= da_sel;
      step_r <= '0;
      for (int i = 0; i < 3; i++) begin
        err_r[i] <= $signed({2'b00, d_r[i], 1'b0}) - $signed({3'b000, da_sel});
      end
    end
    if (state_r == S_WALK) begin
      step_r <= step_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
        err_r[i] <= err_nxt[i];
      end
    end
    p1_addr_r  <= mem_raddr;
    p1_write_r <= (state_r == S_WALK);
    p1_last_r  <= (state_r == S_READ) || walk_last;
    p1_cnt_r   <= (state_r == S_READ) ? '0 : {1'b0, da_r} + 1'b1;
    if (p1_valid_r && p1_last_r) begin
      out_cnt_r <= p1_cnt_r;
      out_lo_r  <= p1_write_r ? sat_val : mem_rdata;
    end
  end

  rclo_ram #(
    .WIDTH(LOG_ODDS_BITS),
    .DEPTH(CELL_COUNT)
  ) u_grid (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_valid              = out_valid_r;
  assign out_data.cells_updated = out_cnt_r;
  assign out_data.end_log_odds  = out_lo_r;
  assign out_data.end_occupied  = (out_lo_r > occ_thresh_r);

`ifndef ASSERT_OFF
  // consecutive walk writes hit distinct voxels, so no forwarding is needed
  a_distinct_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && p1_write_r && $past(p1_valid_r && p1_write_r))
      |-> (p1_addr_r != $past(p1_addr_r)))
    else $error("back-to-back read-modify-write to the same voxel");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_WALK || state_r == S_DRAIN))
    else $error("grid write outside clear, walk or drain");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (step_r <= da_r))
    else $error("walk step counter ran past the driving extent");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(p1_valid_r) && $past(p1_last_r)))
    else $error("result strobe without a finished last access");
`endif

endmodule
`default_nettype wire
